// ----- rtl/cunrank_pkg.sv -----
// Shared constants and controller/datapath interface types for the combination unrank unit.
package cunrank_pkg;

    localparam int MAX_ITEMS_DEF = 32;
    localparam int MASK_W        = 32;
    localparam int RANK_W        = 32;
    localparam int K_W           = 6;
    localparam int CAND_W        = 5;
    localparam int BINOM_W       = 32;
    localparam int IN_TDATA_W    = 40;

    localparam logic [K_W-1:0] ITEM_COUNT_RST = 6'd32;

    typedef struct packed {
        logic              load;
        logic              build;
        logic              check;
        logic              step;
        logic              emit;
        logic [CAND_W-1:0] cand;
    } cu_cmd_t;

    typedef struct packed {
        logic           out_free;
        logic [K_W-1:0] item_n;
    } cu_sts_t;

endpackage

// ----- rtl/combination_unrank_unit.sv -----
// Combination unrank unit: decodes a combinadic rank into a k-subset membership mask.
// An item passes through these steps in order: acceptance; a build phase in which a row of
// Pascal-triangle lanes builds the column C(c, k) for c = 0..n; a range check against
// C(n, k); greedy descent over the candidates n-1 down to 0 (one candidate a cycle); and
// the load of the output register, which waits until that register is free. Here n is
// item_count limited to min(MAX_ITEMS, 32). One item is in work at a time; the next is
// accepted as soon as the previous one has moved into the output register, even while
// that result still waits to be taken.
// A rank at or above C(n, k), or k above n, gives rank_invalid (tuser) set and an empty
// mask.
module combination_unrank_unit
    import cunrank_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [K_W-1:0]        cfg_wr_data,    // item_count
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // rank_value[31:0], choose_count[37:32]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [MASK_W-1:0]     m_axis_tdata,   // member_mask[31:0]
    output logic                  m_axis_tuser    // rank_invalid
);

    cu_cmd_t cmd;
    cu_sts_t sts;

    cunrank_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cunrank_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_rank     (s_axis_tdata[RANK_W-1:0]),
        .in_k        (s_axis_tdata[RANK_W+K_W-1:RANK_W]),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_mask    (m_axis_tdata),
        .out_invalid (m_axis_tuser)
    );

endmodule

// ----- rtl/cunrank_ctrl.sv -----
// Sequencer for the combination unrank unit: build, range check, descent, result.
module cunrank_ctrl
    import cunrank_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  cu_sts_t sts,
    output cu_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_BUILD = 5'b00010,
        S_CHECK = 5'b00100,
        S_DESC  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic [K_W-1:0] cnt_reg, cnt_next;
    logic [K_W-1:0] n_reg, n_next;
    logic [K_W-1:0] cnt_dec;

    assign cnt_dec  = cnt_reg - K_W'(1);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        cmd        = '0;
        cmd.cand   = cnt_dec[CAND_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    n_next     = sts.item_n;
                    cnt_next   = '0;
                    state_next = S_BUILD;
                end
            end
            S_BUILD:
            begin
                // one Pascal row per cycle, rows 0..n
                cmd.build = 1'b1;
                if (cnt_reg == n_reg)
                    state_next = S_CHECK;
                else
                    cnt_next = cnt_reg + K_W'(1);
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                cnt_next  = n_reg;
                if (n_reg == '0)
                    state_next = S_DONE;
                else
                    state_next = S_DESC;
            end
            S_DESC:
            begin
                // candidate is cnt-1, running n-1 down to 0
                cmd.step = 1'b1;
                cnt_next = cnt_dec;
                if (cnt_reg == K_W'(1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
        end
    end

endmodule

// ----- rtl/cunrank_dp.sv -----
// Datapath: Pascal row lanes, binomial column lanes, greedy descent and output register.
module cunrank_dp
    import cunrank_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [K_W-1:0]    cfg_wr_data,
    input  logic [RANK_W-1:0] in_rank,
    input  logic [K_W-1:0]    in_k,
    input  cu_cmd_t           cmd,
    output cu_sts_t           sts,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [MASK_W-1:0] out_mask,
    output logic              out_invalid
);

    localparam int NMAX  = (MAX_ITEMS < MASK_W) ? MAX_ITEMS : MASK_W;
    localparam int LANES = NMAX + 1;

    logic [K_W-1:0]     item_count_reg;
    logic               out_valid_reg;
    logic [MASK_W-1:0]  out_mask_reg;
    logic               out_inv_reg;

    logic [RANK_W-1:0]  rank_reg;
    logic [K_W-1:0]     k_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic               invalid_reg;
    logic [BINOM_W-1:0] row_reg [LANES];
    logic [BINOM_W-1:0] col_reg [LANES];

    logic [BINOM_W-1:0] lane_sel;
    logic [BINOM_W-1:0] col_up [LANES];
    logic               take;

    assign sts.item_n   = (item_count_reg > K_W'(NMAX)) ? K_W'(NMAX) : item_count_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    // entry k of the current Pascal row; zero when k is past the last lane
    always_comb
    begin
        lane_sel = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (k_reg == K_W'(i))
                lane_sel = row_reg[i];
        end
    end

    // col_reg[j] holds C(cand - j, k); the lane above the top reads as zero
    always_comb
    begin
        for (int j = 0; j < LANES - 1; j++)
            col_up[j] = col_reg[j+1];
        col_up[LANES-1] = '0;
    end

    assign take = (k_reg != '0) && (col_reg[0] <= rank_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rank_reg <= in_rank;
            k_reg    <= in_k;
            mask_reg <= '0;
            for (int j = 0; j < LANES; j++)
            begin
                row_reg[j] <= (j == 0) ? BINOM_W'(1) : '0;
                col_reg[j] <= '0;
            end
        end
        else if (cmd.build)
        begin
            col_reg[0] <= lane_sel;
            for (int j = 1; j < LANES; j++)
            begin
                row_reg[j] <= row_reg[j] + row_reg[j-1];
                col_reg[j] <= col_reg[j-1];
            end
        end
        else if (cmd.check)
        begin
            invalid_reg <= (rank_reg >= col_reg[0]);
            for (int j = 0; j < LANES; j++)
                col_reg[j] <= col_up[j];
        end
        else if (cmd.step)
        begin
            if (take)
            begin
                rank_reg           <= rank_reg - col_reg[0];
                k_reg              <= k_reg - K_W'(1);
                mask_reg[cmd.cand] <= 1'b1;
                // C(c, k-1) = C(c+1, k) - C(c, k), shifted down one candidate
                for (int j = 0; j < LANES; j++)
                    col_reg[j] <= col_reg[j] - col_up[j];
            end
            else
            begin
                for (int j = 0; j < LANES; j++)
                    col_reg[j] <= col_up[j];
            end
        end

        if (cmd.emit)
        begin
            out_mask_reg <= invalid_reg ? '0 : mask_reg;
            out_inv_reg  <= invalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= ITEM_COUNT_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                item_count_reg <= cfg_wr_data;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_mask    = out_mask_reg;
    assign out_invalid = out_inv_reg;

endmodule

// ----- rtl/cunrank_checker.sv -----
// Port-level checks for the combination unrank unit, bound to the top level.
module cunrank_checker
    import cunrank_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [MASK_W-1:0]     m_axis_tdata,
    input logic                  m_axis_tuser
);

    // result held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item accepted while one is in work");

    a_invalid_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("invalid rank with non-empty mask");

endmodule

bind combination_unrank_unit cunrank_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
